[hw/rtl/ipv4_longest_prefix_route_table_defines.svh]
// Assertion macros for the route table.
`ifndef IPV4_LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH

// same-cycle implication
`define LPMRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("route table assertion failed");

// next-cycle implication
`define LPMRT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("route table assertion failed");

`endif

[hw/rtl/lpmrt_pkg.sv]
// Shared types, codes and helpers of the route table.
package lpmrt_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_ROUTE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [5:0] LEN_MAX = 6'd32;

	// request walking the chain with its running results
	typedef struct packed {
		logic        act;
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [5:0]  len;
		logic [15:0] ifx;
		logic [31:0] nh;
		logic        found;
		logic        hit;
		logic        free_found;
		logic [5:0]  best_len;
		logic [15:0] best_if;
		logic [31:0] best_nh;
	} token_t;

	// slot write from the tail
	typedef struct packed {
		logic        en;
		logic [31:0] pfx;
		logic [5:0]  len;
		logic [15:0] ifx;
		logic [31:0] nh;
	} wr_t;

	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'h0;
		end else if (len >= LEN_MAX) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = 32'hFFFF_FFFF << (6'd32 - len);
		end
		return m;
	endfunction

endpackage

[hw/rtl/ipv4_longest_prefix_route_table.sv]
// Top level of the IPv4 longest-prefix-match route table.
// Each request (lookup, insert or remove) is registered at the head, walks a
// chain of ENTRIES slot cells, one cell per cycle, and its result passes
// through a tail register into the output register. One request is in the
// chain at a time: the next request is taken once the previous result has
// moved into the output register (which may still wait for the sink), so no
// new request is accepted before the previous one is through. Lookups return
// the longest valid matching prefix; new routes take the lowest free slot, and
// a full table returns status 2. All slots are invalid after reset.
`include "ipv4_longest_prefix_route_table_defines.svh"

module ipv4_longest_prefix_route_table #(
	parameter int ENTRIES = lpmrt_pkg::ENTRIES_DEF,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // address, prefix_len, route_if_index, route_next_hop, pad
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // out_if_index, out_next_hop
	output logic [1:0]  m_tuser   // status
);

	lpmrt_pkg::token_t tok [ENTRIES+1];
	logic [IW-1:0]     fr  [ENTRIES+1];

	lpmrt_pkg::token_t head_q;
	lpmrt_pkg::token_t tail_q;
	logic [IW-1:0]     tail_free_q;
	logic              tail_vld_q;
	logic              busy_q;
	logic              m_valid_q;
	logic [1:0]        m_status_q;
	logic [15:0]       m_if_q;
	logic [31:0]       m_nh_q;

	lpmrt_pkg::token_t head_nxt;
	lpmrt_pkg::wr_t    wr;
	logic              in_acc;
	logic              out_free;
	logic              finish;
	logic [5:0]        in_len;
	logic [5:0]        sat_len;
	logic [1:0]        res_status;
	logic [15:0]       res_if;
	logic [31:0]       res_nh;

	assign s_tready = !busy_q;
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign finish   = tail_vld_q && out_free;

	assign in_len  = s_tdata[37:32];
	assign sat_len = (in_len > lpmrt_pkg::LEN_MAX) ? lpmrt_pkg::LEN_MAX : in_len;

	always_comb begin
		head_nxt = '0;
		if (in_acc) begin
			head_nxt.act  = 1'b1;
			head_nxt.kind = s_tuser;
			head_nxt.len  = sat_len;
			head_nxt.ifx  = s_tdata[53:38];
			head_nxt.nh   = s_tdata[85:54];
			if (s_tuser == lpmrt_pkg::KIND_LOOKUP) begin
				head_nxt.addr = s_tdata[31:0];
			end else begin
				head_nxt.addr = s_tdata[31:0] & lpmrt_pkg::len_mask(sat_len);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head_nxt;
		end
	end

	assign tok[0] = head_q;
	assign fr[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lpmrt_cell #(
			.ENTRIES(ENTRIES),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_in(tok[i]),
			.free_in(fr[i]),
			.wr(wr),
			.wr_idx(tail_free_q),
			.tok_out(tok[i+1]),
			.free_out(fr[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_vld_q <= 1'b0;
		end else if (tok[ENTRIES].act) begin
			tail_vld_q <= 1'b1;
		end else if (finish) begin
			tail_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[ENTRIES].act) begin
			tail_q      <= tok[ENTRIES];
			tail_free_q <= fr[ENTRIES];
		end
	end

	always_comb begin
		wr.en  = 1'b0;
		wr.pfx = tail_q.addr;
		wr.len = tail_q.len;
		wr.ifx = tail_q.ifx;
		wr.nh  = tail_q.nh;
		res_status = lpmrt_pkg::ST_OK;
		res_if     = 16'h0;
		res_nh     = 32'h0;
		unique case (tail_q.kind)
			lpmrt_pkg::KIND_LOOKUP: begin
				if (tail_q.found) begin
					res_if = tail_q.best_if;
					res_nh = tail_q.best_nh;
				end else begin
					res_status = lpmrt_pkg::ST_NO_ROUTE;
				end
			end
			lpmrt_pkg::KIND_INSERT: begin
				if (!tail_q.hit) begin
					if (tail_q.free_found) begin
						wr.en = finish;
					end else begin
						res_status = lpmrt_pkg::ST_FULL;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_status_q <= res_status;
			m_if_q     <= res_if;
			m_nh_q     <= res_nh;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {m_nh_q, m_if_q};

	`LPMRT_ASSERT_NXT(a_acc_busy, in_acc, busy_q)
	`LPMRT_ASSERT_IMP(a_head_busy, head_q.act, busy_q && !tail_vld_q)
	`LPMRT_ASSERT_IMP(a_tail_busy, tail_vld_q, busy_q)
	`LPMRT_ASSERT_IMP(a_wr_insert, wr.en,
		finish && (tail_q.kind == lpmrt_pkg::KIND_INSERT) && !tail_q.hit)

endmodule

[hw/rtl/lpmrt_cell.sv]
// One route slot of the chain: stores a route and updates the passing request.
module lpmrt_cell #(
	parameter int ENTRIES = lpmrt_pkg::ENTRIES_DEF,
	parameter int IDX = 0,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpmrt_pkg::token_t tok_in,
	input  logic [IW-1:0]     free_in,
	input  lpmrt_pkg::wr_t    wr,
	input  logic [IW-1:0]     wr_idx,
	output lpmrt_pkg::token_t tok_out,
	output logic [IW-1:0]     free_out
);

	logic        valid_q;
	logic [31:0] pfx_q;
	logic [5:0]  len_q;
	logic [15:0] ifx_q;
	logic [31:0] nh_q;

	lpmrt_pkg::token_t tok_q;
	logic [IW-1:0]     free_q;

	lpmrt_pkg::token_t nxt;
	logic [IW-1:0]     nfree;
	logic              match;
	logic              exact;
	logic              ld;
	logic              clr;
	logic              wsel;

	assign match = valid_q && ((tok_in.addr & lpmrt_pkg::len_mask(len_q)) == pfx_q);
	assign exact = valid_q && (len_q == tok_in.len) && (pfx_q == tok_in.addr);
	assign wsel  = wr.en && (wr_idx == IW'(IDX));

	always_comb begin
		nxt   = tok_in;
		nfree = free_in;
		ld    = 1'b0;
		clr   = 1'b0;
		if (tok_in.act) begin
			unique case (tok_in.kind)
				lpmrt_pkg::KIND_LOOKUP: begin
					if (match && (!tok_in.found || len_q > tok_in.best_len)) begin
						nxt.found    = 1'b1;
						nxt.best_len = len_q;
						nxt.best_if  = ifx_q;
						nxt.best_nh  = nh_q;
					end
				end
				lpmrt_pkg::KIND_INSERT: begin
					if (exact) begin
						nxt.hit = 1'b1;
						ld      = 1'b1;
					end else if (!valid_q && !tok_in.free_found) begin
						nxt.free_found = 1'b1;
						nfree          = IW'(IDX);
					end
				end
				lpmrt_pkg::KIND_REMOVE: begin
					if (exact) begin
						nxt.hit = 1'b1;
						clr     = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wsel) begin
			valid_q <= 1'b1;
		end else if (clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wsel) begin
			pfx_q <= wr.pfx;
			len_q <= wr.len;
			ifx_q <= wr.ifx;
			nh_q  <= wr.nh;
		end else if (ld) begin
			ifx_q <= tok_in.ifx;
			nh_q  <= tok_in.nh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			free_q <= '0;
		end else begin
			tok_q  <= nxt;
			free_q <= nfree;
		end
	end

	assign tok_out  = tok_q;
	assign free_out = free_q;

endmodule

[tb/ipv4_longest_prefix_route_table_tb.sv]
// Testbench for the IPv4 longest-prefix-match route table: directed and random requests.
module ipv4_longest_prefix_route_table_tb;

	localparam int ROUTE_SLOTS = lpmrt_pkg::ENTRIES_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SINK_HOLD = 300;
	localparam int LIMIT_CYCLES = 1_000_000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] ifx;
		logic [31:0] nh;
	} route_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;  // address, prefix_len, route_if_index, route_next_hop, pad
	logic [1:0]  s_tuser = '0;  // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;       // out_if_index, out_next_hop
	logic [1:0]  m_tuser;       // status

	// model of the table
	bit          rt_valid [ROUTE_SLOTS];
	logic [31:0] rt_prefix[ROUTE_SLOTS];
	logic [5:0]  rt_len   [ROUTE_SLOTS];
	logic [15:0] rt_if    [ROUTE_SLOTS];
	logic [31:0] rt_nh    [ROUTE_SLOTS];

	route_reply_t route_replies_q[$];
	logic [31:0]  pool_addr[$];
	logic [5:0]   pool_len[$];

	int mismatches = 0;
	int cycles = 0;
	int sink_wait = 0;
	bit sink_hold_req = 1'b0;
	bit calm = 1'b0;

	ipv4_longest_prefix_route_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		return ~(32'hFFFF_FFFF >> len);
	endfunction

	function automatic int route_slot(input logic [31:0] pfx, input logic [5:0] len);
		for (int i = 0; i < ROUTE_SLOTS; i++) begin
			if (rt_valid[i] && rt_len[i] == len && rt_prefix[i] == pfx) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int free_slots();
		int n;
		n = 0;
		for (int i = 0; i < ROUTE_SLOTS; i++) begin
			if (!rt_valid[i]) begin
				n++;
			end
		end
		return n;
	endfunction

	function automatic route_reply_t route_table_apply(input logic [1:0] kind,
			input logic [31:0] addr, input logic [5:0] len_in,
			input logic [15:0] ifx, input logic [31:0] nh);
		route_reply_t r;
		logic [5:0]   len;
		logic [31:0]  pfx;
		int           best;
		int           slot;
		r = '0;
		r.status = lpmrt_pkg::ST_OK;
		len = (len_in > lpmrt_pkg::LEN_MAX) ? lpmrt_pkg::LEN_MAX : len_in;
		pfx = addr & prefix_mask(len);
		case (kind)
			lpmrt_pkg::KIND_LOOKUP: begin
				best = -1;
				for (int i = 0; i < ROUTE_SLOTS; i++) begin
					if (rt_valid[i] && (addr & prefix_mask(rt_len[i])) == rt_prefix[i]
							&& (best < 0 || rt_len[i] > rt_len[best])) begin
						best = i;
					end
				end
				if (best < 0) begin
					r.status = lpmrt_pkg::ST_NO_ROUTE;
				end else begin
					r.ifx = rt_if[best];
					r.nh = rt_nh[best];
				end
			end
			lpmrt_pkg::KIND_INSERT: begin
				slot = route_slot(pfx, len);
				for (int i = 0; i < ROUTE_SLOTS && slot < 0; i++) begin
					if (!rt_valid[i]) begin
						slot = i;
					end
				end
				if (slot < 0) begin
					r.status = lpmrt_pkg::ST_FULL;
				end else begin
					rt_valid[slot] = 1'b1;
					rt_prefix[slot] = pfx;
					rt_len[slot] = len;
					rt_if[slot] = ifx;
					rt_nh[slot] = nh;
				end
			end
			lpmrt_pkg::KIND_REMOVE: begin
				slot = route_slot(pfx, len);
				if (slot >= 0) begin
					rt_valid[slot] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
			input logic [5:0] len, input logic [15:0] ifx, input logic [31:0] nh);
		bit rdy;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, nh, ifx, len, addr};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		route_replies_q.insert(route_replies_q.size(),
			route_table_apply(kind, addr, len, ifx, nh));
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic wait_replies();
		s_tvalid <= 1'b0;
		while (route_replies_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [5:0] rand_prefix_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 6'd0;
		if (r < 12) return 6'd32;
		if (r < 17) return 6'($urandom_range(33, 63));
		if (r < 35) return 6'(8 * $urandom_range(1, 3));
		return 6'($urandom_range(1, 31));
	endfunction

	task automatic insert_new_route();
		logic [31:0] a;
		logic [5:0]  l;
		a = $urandom();
		l = rand_prefix_len();
		pool_addr.insert(pool_addr.size(), a);
		pool_len.insert(pool_len.size(), l);
		if (pool_addr.size() > 256) begin
			void'(pool_addr.pop_front());
			void'(pool_len.pop_front());
		end
		send_request(lpmrt_pkg::KIND_INSERT, a, l, 16'($urandom()), $urandom());
	endtask

	task automatic random_request();
		int          r;
		int          p;
		logic [31:0] a;
		logic [31:0] m;
		logic [5:0]  l;
		r = $urandom_range(0, 99);
		p = (pool_addr.size() != 0) ? $urandom_range(0, pool_addr.size() - 1) : -1;
		if (p >= 0) begin
			l = pool_len[p];
			m = prefix_mask((l > lpmrt_pkg::LEN_MAX) ? lpmrt_pkg::LEN_MAX : l);
			a = (pool_addr[p] & m) | ($urandom() & ~m);
		end
		if (r < 45) begin
			if (p < 0 || $urandom_range(0, 4) == 0) begin
				a = $urandom();
			end else if ($urandom_range(0, 9) == 0) begin
				a ^= 32'd1 << $urandom_range(0, 31);
			end
			send_request(lpmrt_pkg::KIND_LOOKUP, a, 6'($urandom()), 16'($urandom()),
				$urandom());
		end else if (r < 75) begin
			if (p >= 0 && $urandom_range(0, 2) == 0) begin
				send_request(lpmrt_pkg::KIND_INSERT, a, l, 16'($urandom()), $urandom());
			end else begin
				insert_new_route();
			end
		end else if (r < 95) begin
			if (p < 0 || $urandom_range(0, 3) == 0) begin
				a = $urandom();
				l = rand_prefix_len();
			end
			send_request(lpmrt_pkg::KIND_REMOVE, a, l, 16'($urandom()), $urandom());
		end else begin
			send_request(KIND_UNUSED, $urandom(), 6'($urandom()), 16'($urandom()),
				$urandom());
		end
	endtask

	task automatic test_directed();
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 6'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(lpmrt_pkg::KIND_INSERT, 32'h0A00_0000, 6'd8, 16'd1, 32'h0A00_0001);
		send_request(lpmrt_pkg::KIND_INSERT, 32'h0A01_0000, 6'd16, 16'd2, 32'h0A01_0001);
		send_request(lpmrt_pkg::KIND_INSERT, 32'h0A01_0203, 6'd32, 16'd3, 32'h0A01_0201);
		send_request(lpmrt_pkg::KIND_INSERT, 32'h0A01_0203, 6'd63, 16'd4, 32'h0);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0A01_0203, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0A01_0204, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0A02_0000, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0B00_0000, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_INSERT, 32'h0A01_0000, 6'd16, 16'd5, 32'h0A01_0005);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0A01_0909, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_REMOVE, 32'h0A01_FFFF, 6'd16, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'h0A01_0909, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_REMOVE, 32'hC0A8_0000, 6'd24, 16'h0, 32'h0);
		send_request(KIND_UNUSED, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(lpmrt_pkg::KIND_REMOVE, 32'h1234_5678, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0, 32'h0);
		send_request(lpmrt_pkg::KIND_INSERT, 32'h8000_0000, 6'd1, 16'hAAAA, 32'h5555_5555);
		send_request(lpmrt_pkg::KIND_LOOKUP, 32'hC000_0000, 6'd0, 16'h0, 32'h0);
	endtask

	// fill every slot, overflow, replace while full, then empty the table
	task automatic test_table_full();
		int i;
		while (free_slots() > 0) begin
			insert_new_route();
		end
		send_request(lpmrt_pkg::KIND_INSERT, 32'h0102_0304, 6'd31, 16'h1234, 32'h0506_0708);
		i = $urandom_range(0, ROUTE_SLOTS - 1);
		send_request(lpmrt_pkg::KIND_INSERT, rt_prefix[i], rt_len[i], 16'hBEEF,
			32'hCAFE_F00D);
		send_request(lpmrt_pkg::KIND_LOOKUP, rt_prefix[i], 6'd0, 16'h0, 32'h0);
		for (i = 0; i < ROUTE_SLOTS; i++) begin
			if (rt_valid[i]) begin
				send_request(lpmrt_pkg::KIND_REMOVE, rt_prefix[i], rt_len[i],
					16'($urandom()), $urandom());
			end
		end
		send_request(lpmrt_pkg::KIND_LOOKUP, $urandom(), 6'd0, 16'h0, 32'h0);
	endtask

	task automatic test_backpressure();
		sink_hold_req = 1'b1;
		repeat (10) random_request();
	endtask

	task automatic test_drain_pause();
		wait_replies();
		repeat ($urandom_range(20, 60)) @(posedge clk);
		repeat (10) random_request();
	endtask

	task automatic test_random(input int count);
		repeat (count) random_request();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold_req) begin
			sink_hold_req = 1'b0;
			sink_wait = SINK_HOLD - 1;
			m_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			sink_wait = $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// both sides are driven at the rising edge, so the handshake is visible here
	always @(negedge clk) begin : check_reply
		route_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (route_replies_q.size() == 0) begin
				$display("%0t: unexpected reply status=%0d if=%h nh=%h", $time,
					m_tuser, m_tdata[15:0], m_tdata[47:16]);
				mismatches++;
			end else begin
				want = route_replies_q.pop_front();
				if (m_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[15:0] !== want.ifx) begin
					$display("%0t: out_if_index expected %h actual %h", $time,
						want.ifx, m_tdata[15:0]);
					mismatches++;
				end
				if (m_tdata[47:16] !== want.nh) begin
					$display("%0t: out_next_hop expected %h actual %h", $time,
						want.nh, m_tdata[47:16]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random(800);
		test_drain_pause();
		test_random(800);
		calm = 1'b1;
		test_random(300);
		wait_replies();
		repeat (ROUTE_SLOTS + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lpmrt_pkg.sv
hw/rtl/lpmrt_cell.sv
hw/rtl/ipv4_longest_prefix_route_table.sv
tb/ipv4_longest_prefix_route_table_tb.sv
